### rtl/core/dsns_pkg.sv
// Package for the double SHA-512 nonce search core: beat types, round
// constants and SHA-512 helper functions. No dependencies.
`default_nettype none
package dsns_pkg;

  typedef struct packed {
    logic [63:0] initial_hash_w0;
    logic [63:0] initial_hash_w1;
    logic [63:0] initial_hash_w2;
    logic [63:0] initial_hash_w3;
    logic [63:0] initial_hash_w4;
    logic [63:0] initial_hash_w5;
    logic [63:0] initial_hash_w6;
    logic [63:0] initial_hash_w7;
    logic [63:0] work_target;
  } dsns_in_t;

  typedef struct packed {
    logic [63:0] found_nonce;
    logic [63:0] trial_value;
  } dsns_out_t;

  typedef logic [63:0] word_t;
  typedef word_t [7:0] hash_t;

  localparam word_t PAD_WORD = 64'h8000000000000000;
  localparam word_t LEN1     = 64'd576;
  localparam word_t LEN2     = 64'd512;
  localparam word_t ALL_ONES = 64'hffffffffffffffff;

  localparam hash_t START_H = {
    64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b, 64'h9b05688c2b3e6c1f,
    64'h510e527fade682d1, 64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b,
    64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908};

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  function automatic word_t round_k(input logic [6:0] i);
    unique case (i)
      7'd0:  round_k = 64'h428a2f98d728ae22; 7'd1:  round_k = 64'h7137449123ef65cd;
      7'd2:  round_k = 64'hb5c0fbcfec4d3b2f; 7'd3:  round_k = 64'he9b5dba58189dbbc;
      7'd4:  round_k = 64'h3956c25bf348b538; 7'd5:  round_k = 64'h59f111f1b605d019;
      7'd6:  round_k = 64'h923f82a4af194f9b; 7'd7:  round_k = 64'hab1c5ed5da6d8118;
      7'd8:  round_k = 64'hd807aa98a3030242; 7'd9:  round_k = 64'h12835b0145706fbe;
      7'd10: round_k = 64'h243185be4ee4b28c; 7'd11: round_k = 64'h550c7dc3d5ffb4e2;
      7'd12: round_k = 64'h72be5d74f27b896f; 7'd13: round_k = 64'h80deb1fe3b1696b1;
      7'd14: round_k = 64'h9bdc06a725c71235; 7'd15: round_k = 64'hc19bf174cf692694;
      7'd16: round_k = 64'he49b69c19ef14ad2; 7'd17: round_k = 64'hefbe4786384f25e3;
      7'd18: round_k = 64'h0fc19dc68b8cd5b5; 7'd19: round_k = 64'h240ca1cc77ac9c65;
      7'd20: round_k = 64'h2de92c6f592b0275; 7'd21: round_k = 64'h4a7484aa6ea6e483;
      7'd22: round_k = 64'h5cb0a9dcbd41fbd4; 7'd23: round_k = 64'h76f988da831153b5;
      7'd24: round_k = 64'h983e5152ee66dfab; 7'd25: round_k = 64'ha831c66d2db43210;
      7'd26: round_k = 64'hb00327c898fb213f; 7'd27: round_k = 64'hbf597fc7beef0ee4;
      7'd28: round_k = 64'hc6e00bf33da88fc2; 7'd29: round_k = 64'hd5a79147930aa725;
      7'd30: round_k = 64'h06ca6351e003826f; 7'd31: round_k = 64'h142929670a0e6e70;
      7'd32: round_k = 64'h27b70a8546d22ffc; 7'd33: round_k = 64'h2e1b21385c26c926;
      7'd34: round_k = 64'h4d2c6dfc5ac42aed; 7'd35: round_k = 64'h53380d139d95b3df;
      7'd36: round_k = 64'h650a73548baf63de; 7'd37: round_k = 64'h766a0abb3c77b2a8;
      7'd38: round_k = 64'h81c2c92e47edaee6; 7'd39: round_k = 64'h92722c851482353b;
      7'd40: round_k = 64'ha2bfe8a14cf10364; 7'd41: round_k = 64'ha81a664bbc423001;
      7'd42: round_k = 64'hc24b8b70d0f89791; 7'd43: round_k = 64'hc76c51a30654be30;
      7'd44: round_k = 64'hd192e819d6ef5218; 7'd45: round_k = 64'hd69906245565a910;
      7'd46: round_k = 64'hf40e35855771202a; 7'd47: round_k = 64'h106aa07032bbd1b8;
      7'd48: round_k = 64'h19a4c116b8d2d0c8; 7'd49: round_k = 64'h1e376c085141ab53;
      7'd50: round_k = 64'h2748774cdf8eeb99; 7'd51: round_k = 64'h34b0bcb5e19b48a8;
      7'd52: round_k = 64'h391c0cb3c5c95a63; 7'd53: round_k = 64'h4ed8aa4ae3418acb;
      7'd54: round_k = 64'h5b9cca4f7763e373; 7'd55: round_k = 64'h682e6ff3d6b2b8a3;
      7'd56: round_k = 64'h748f82ee5defb2fc; 7'd57: round_k = 64'h78a5636f43172f60;
      7'd58: round_k = 64'h84c87814a1f0ab72; 7'd59: round_k = 64'h8cc702081a6439ec;
      7'd60: round_k = 64'h90befffa23631e28; 7'd61: round_k = 64'ha4506cebde82bde9;
      7'd62: round_k = 64'hbef9a3f7b2c67915; 7'd63: round_k = 64'hc67178f2e372532b;
      7'd64: round_k = 64'hca273eceea26619c; 7'd65: round_k = 64'hd186b8c721c0c207;
      7'd66: round_k = 64'heada7dd6cde0eb1e; 7'd67: round_k = 64'hf57d4f7fee6ed178;
      7'd68: round_k = 64'h06f067aa72176fba; 7'd69: round_k = 64'h0a637dc5a2c898a6;
      7'd70: round_k = 64'h113f9804bef90dae; 7'd71: round_k = 64'h1b710b35131c471b;
      7'd72: round_k = 64'h28db77f523047d84; 7'd73: round_k = 64'h32caab7b40c72493;
      7'd74: round_k = 64'h3c9ebe0a15c9bebc; 7'd75: round_k = 64'h431d67c49c100d4c;
      7'd76: round_k = 64'h4cc5d4becb3e42b6; 7'd77: round_k = 64'h597f299cfc657e2a;
      7'd78: round_k = 64'h5fcb6fab3ad6faec; 7'd79: round_k = 64'h6c44198c4a475817;
      default: round_k = '0;
    endcase
  endfunction

endpackage
`default_nettype wire

### rtl/core/dsns_round.sv
// One SHA-512 compression round plus message schedule step, shared by every
// round of both hashes. Depends on dsns_pkg.
`default_nettype none
module dsns_round
  import dsns_pkg::*;
(
  input  var hash_t          st_i,
  input  var word_t [15:0]   win_i,
  input  var logic  [6:0]    rnd_i,
  output hash_t              st_o,
  output word_t [15:0]       win_o
);
  word_t s0, s1, t1, t2, wnew, a, e;

  always_comb begin
    a    = st_i[0];
    e    = st_i[4];
    s0   = rotr(win_i[1], 1) ^ rotr(win_i[1], 8) ^ (win_i[1] >> 7);
    s1   = rotr(win_i[14], 19) ^ rotr(win_i[14], 61) ^ (win_i[14] >> 6);
    wnew = win_i[0] + s0 + win_i[9] + s1;
    t1   = st_i[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41))
         + ((e & st_i[5]) ^ (~e & st_i[6])) + round_k(rnd_i) + win_i[0];
    t2   = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39))
         + ((a & st_i[1]) ^ (a & st_i[2]) ^ (st_i[1] & st_i[2]));
    st_o = {st_i[6:4], st_i[3] + t1, st_i[2:0], t1 + t2};
    win_o = {wnew, win_i[15:1]};
  end
endmodule
`default_nettype wire

### rtl/core/double_sha512_nonce_search_core.sv
// Top level of the double SHA-512 nonce search core: sequencer, job registers
// and shared round unit. Depends on dsns_pkg and dsns_round.
//
// One job beat starts a search from nonce 1. Each trial runs two 80-round
// SHA-512 compressions through one round unit at one round per cycle, plus
// a check state that compares the trial value with the target. The input
// is not ready during a search; the result beat is held until taken. An
// exhausted search returns nonce 0 with trial value all ones.
`default_nettype none
module double_sha512_nonce_search_core
  import dsns_pkg::*;
(
  input  var logic      clk,
  input  var logic      rst_n,
  input  var logic      in_valid,
  output logic          in_ready,
  input  var dsns_in_t  in_data,
  output logic          out_valid,
  input  var logic      out_ready,
  output dsns_out_t     out_data
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_H1 = 5'b00010, S_H2 = 5'b00100,
    S_CHK  = 5'b01000, S_OUT = 5'b10000
  } state_t;

  state_t       state_r, state_nxt;
  hash_t        ih_r, st_r, st_nxt;
  word_t [15:0] win_r, win_nxt;
  word_t        tgt_r, nonce_r, nonce_nxt;
  logic  [6:0]  rnd_r, rnd_nxt;
  hash_t        rst_o;
  word_t [15:0] rwin_o;
  hash_t        d1;
  word_t        d2;
  dsns_out_t    res_r, res_nxt;

  dsns_round u_round (.st_i(st_r), .win_i(win_r), .rnd_i(rnd_r),
                      .st_o(rst_o), .win_o(rwin_o));

  always_comb begin
    for (int i = 0; i < 8; i++) d1[i] = START_H[i] + rst_o[i];
  end
  assign d2 = START_H[0] + st_r[0];

  function automatic word_t [15:0] blk1(input word_t n, input hash_t ih);
    blk1 = {LEN1, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, PAD_WORD,
            ih[7], ih[6], ih[5], ih[4], ih[3], ih[2], ih[1], ih[0], n};
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = res_r;

  always_comb begin
    state_nxt = state_r;
    st_nxt    = rst_o;
    win_nxt   = rwin_o;
    rnd_nxt   = rnd_r + 7'd1;
    nonce_nxt = nonce_r;
    res_nxt   = res_r;
    unique case (state_r)
      S_IDLE: begin
        rnd_nxt = '0;
        if (in_valid) begin
          state_nxt = S_H1;
          nonce_nxt = 64'd1;
          st_nxt    = START_H;
          win_nxt   = blk1(64'd1, {in_data.initial_hash_w7, in_data.initial_hash_w6,
                        in_data.initial_hash_w5, in_data.initial_hash_w4,
                        in_data.initial_hash_w3, in_data.initial_hash_w2,
                        in_data.initial_hash_w1, in_data.initial_hash_w0});
        end
      end
      S_H1: begin
        if (rnd_r == 7'd79) begin
          state_nxt = S_H2;
          rnd_nxt   = '0;
          st_nxt    = START_H;
          win_nxt   = {LEN2, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, PAD_WORD,
                       d1[7], d1[6], d1[5], d1[4], d1[3], d1[2], d1[1], d1[0]};
        end
      end
      S_H2: begin
        if (rnd_r == 7'd79) begin
          state_nxt = S_CHK;
          rnd_nxt   = '0;
        end
      end
      S_CHK: begin
        rnd_nxt = '0;
        st_nxt  = START_H;
        win_nxt = blk1(nonce_r + 64'd1, ih_r);
        if (d2 <= tgt_r) begin
          state_nxt = S_OUT;
          res_nxt   = '{found_nonce: nonce_r, trial_value: d2};
        end else if (nonce_r == 64'd0) begin
          state_nxt = S_OUT;
          res_nxt   = '{found_nonce: 64'd0, trial_value: ALL_ONES};
        end else begin
          state_nxt = S_H1;
          nonce_nxt = nonce_r + 64'd1;
        end
      end
      S_OUT: begin
        rnd_nxt = '0;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    st_r    <= st_nxt;
    win_r   <= win_nxt;
    rnd_r   <= rnd_nxt;
    nonce_r <= nonce_nxt;
    res_r   <= res_nxt;
    if (in_ready && in_valid) begin
      ih_r  <= {in_data.initial_hash_w7, in_data.initial_hash_w6,
                in_data.initial_hash_w5, in_data.initial_hash_w4,
                in_data.initial_hash_w3, in_data.initial_hash_w2,
                in_data.initial_hash_w1, in_data.initial_hash_w0};
      tgt_r <= in_data.work_target;
    end
  end
endmodule
`default_nettype wire

### bench/double_sha512_nonce_search_core_test.sv
// Testbench for double_sha512_nonce_search_core: random and directed jobs,
// a built-in double SHA-512 search predictor and a result scoreboard.
// Depends on dsns_pkg and the core RTL.
`timescale 1ns / 100ps
`default_nettype none
module double_sha512_nonce_search_core_test;
  import dsns_pkg::*;

  typedef logic [15:0][63:0] block_t;
  typedef logic [7:0][63:0] digest_t;

  localparam logic [63:0] MAX_WORD = 64'hffffffffffffffff;
  localparam int LONG_HOLD = 1500;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  dsns_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  dsns_out_t out_data;

  dsns_in_t job_q[$];
  dsns_out_t found_q[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  int errors = 0;

  logic [63:0] kc[80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

  logic [63:0] iv[8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

  double_sha512_nonce_search_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data));

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic digest_t sha512_block(input block_t blk);
    logic [63:0] w[80];
    logic [63:0] v[8];
    logic [63:0] t1, t2;
    digest_t d;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 80; i++) begin
      w[i] = w[i-16] + w[i-7]
           + (ror64(w[i-15], 1) ^ ror64(w[i-15], 8) ^ (w[i-15] >> 7))
           + (ror64(w[i-2], 19) ^ ror64(w[i-2], 61) ^ (w[i-2] >> 6));
    end
    for (int i = 0; i < 8; i++) v[i] = iv[i];
    for (int i = 0; i < 80; i++) begin
      t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kc[i] + w[i];
      t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int j = 7; j > 0; j--) v[j] = v[j-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) d[i] = iv[i] + v[i];
    return d;
  endfunction

  function automatic logic [63:0] pow_trial(input logic [63:0] nonce, input dsns_in_t job);
    block_t blk;
    digest_t d1, d2;
    blk = '0;
    blk[0] = nonce;
    blk[1] = job.initial_hash_w0; blk[2] = job.initial_hash_w1;
    blk[3] = job.initial_hash_w2; blk[4] = job.initial_hash_w3;
    blk[5] = job.initial_hash_w4; blk[6] = job.initial_hash_w5;
    blk[7] = job.initial_hash_w6; blk[8] = job.initial_hash_w7;
    blk[9] = 64'h8000000000000000;
    blk[15] = 64'd576;
    d1 = sha512_block(blk);
    blk = '0;
    for (int i = 0; i < 8; i++) blk[i] = d1[i];
    blk[8] = 64'h8000000000000000;
    blk[15] = 64'd512;
    d2 = sha512_block(blk);
    return d2[0];
  endfunction

  // targets used here keep the search to a few trials, so no wrap is reached
  function automatic dsns_out_t search_nonce(input dsns_in_t job);
    dsns_out_t r;
    logic [63:0] nonce;
    logic [63:0] t;
    nonce = 64'd1;
    forever begin
      t = pow_trial(nonce, job);
      if (t <= job.work_target) break;
      nonce++;
      if (nonce == 64'd1) begin
        r.found_nonce = '0;
        r.trial_value = MAX_WORD;
        return r;
      end
    end
    r.found_nonce = nonce;
    r.trial_value = t;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_target();
    int sel;
    logic [63:0] r;
    sel = $urandom_range(0, 9);
    r = rand64();
    if (sel == 0) return {2'b01, r[61:0]};
    if (sel == 1) return {3'b001, r[60:0]};
    if (sel == 2) return MAX_WORD;
    return {1'b1, r[62:0]};
  endfunction

  function automatic dsns_in_t make_job(input logic [63:0] h, input logic [63:0] tgt);
    dsns_in_t j;
    j = '{h, h, h, h, h, h, h, h, tgt};
    return j;
  endfunction

  function automatic dsns_in_t make_job_rand();
    dsns_in_t j;
    j = '{rand64(), rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
          rand64(), rand_target()};
    return j;
  endfunction

  task automatic queue_job(input dsns_in_t j);
    job_q = {job_q, j};
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) found_q = {found_q, search_nonce(in_data)};
      if (job_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data <= job_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    dsns_out_t exp_r;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (found_q.size() == 0) begin
          $error("unexpected result beat: nonce %h trial %h",
                 out_data.found_nonce, out_data.trial_value);
          errors++;
        end else begin
          exp_r = found_q.pop_front();
          if (out_data.found_nonce !== exp_r.found_nonce) begin
            $error("found_nonce: expected %h, got %h", exp_r.found_nonce, out_data.found_nonce);
            errors++;
          end
          if (out_data.trial_value !== exp_r.trial_value) begin
            $error("trial_value: expected %h, got %h", exp_r.trial_value, out_data.trial_value);
            errors++;
          end
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen <= hold_req;
        hold_cnt <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic drain();
    while (job_q.size() > 0 || in_valid || found_q.size() > 0 || hold_cnt > 0)
      @(posedge clk);
  endtask

  task automatic run_phase(input int idle, input int stall, input int n);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) queue_job(make_job_rand());
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    queue_job(make_job('0, MAX_WORD));
    queue_job(make_job(MAX_WORD, MAX_WORD));
    queue_job(make_job(64'haaaaaaaaaaaaaaaa, MAX_WORD));
    queue_job(make_job(64'h5555555555555555, 64'h8000000000000000));
    queue_job(make_job('0, 64'h7fffffffffffffff));
    queue_job(make_job(MAX_WORD, 64'h3fffffffffffffff));
    queue_job(make_job(64'h0123456789abcdef, 64'h1fffffffffffffff));
    queue_job('{64'h1, 64'h2, 64'h3, 64'h4, 64'h5, 64'h6, 64'h7, 64'h8, MAX_WORD});
    queue_job('{MAX_WORD, '0, MAX_WORD, '0, MAX_WORD, '0, MAX_WORD, '0,
                64'hfffffffffffffffe});
    queue_job(make_job(64'h8000000000000001, 64'h8000000000000001));
    drain();
    run_phase(0, 0, 150);
    run_phase(46, 0, 150);
    run_phase(0, 46, 150);
    run_phase(17, 17, 150);
    // long receiver hold-off while jobs keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (30) queue_job(make_job_rand());
    hold_req = hold_req + 1;
    drain();
    run_phase(0, 0, 110);
    repeat (400) @(posedge clk);
    if (errors == 0)
      $display("double_sha512_nonce_search_core_test: done, clean");
    else
      $display("double_sha512_nonce_search_core_test: done, errors");
    $finish;
  end

  initial begin
    #40000000;
    $display("double_sha512_nonce_search_core_test: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
